// File: rtl/kc_pkg.sv
`default_nettype none

package kc_pkg;

  // Width of the k-mer length register and of the fixed result fields.
  localparam int LEN_W  = 4;
  localparam int CODE_W = 16;
  localparam int OCC_W  = 16;

  // Length that the register holds after reset.
  localparam logic [LEN_W-1:0] KMER_LEN_RESET = 4'd4;

  // Input command codes.
  typedef enum logic {
    CMD_PUSH  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_code_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic sweep;
    logic update;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic emit;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/kc_if.sv
`default_nettype none

// Input channel: one command with its base per transaction.
interface kc_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [1:0] base;

  modport source (output valid, output command, output base, input ready);
  modport sink (input valid, input command, input base, output ready);
endinterface

// Result channel: one counted k-mer per transaction.
interface kc_out_if;
  logic                     valid;
  logic                     ready;
  logic [kc_pkg::CODE_W-1:0] kmer_code;
  logic [kc_pkg::OCC_W-1:0]  occurrences;
  logic                     saturated;

  modport source (output valid, output kmer_code, output occurrences, output saturated,
                  input ready);
  modport sink (input valid, input kmer_code, input occurrences, input saturated,
                output ready);
endinterface

// Configuration channel: writes the k-mer length register.
interface kc_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [kc_pkg::LEN_W-1:0] kmer_length;

  modport source (output valid, output kmer_length, input ready);
  modport sink (input valid, input kmer_length, output ready);
endinterface

`default_nettype wire

// File: rtl/kmer_counter.sv
// Channel   Dir   Payload                                  Transaction when
// in_ch     in    command, base                            valid && ready
// out_ch    out   kmer_code, occurrences, saturated        valid && ready
// cfg_ch    in    kmer_length                              valid && ready (always ready)
//
// A push that completes a k-mer has two steps: accept with table read, then
// the counter read-modify-write into the result register. Other pushes only accept.
// The counter table has a single write port, so reset and every clear command
// start a zeroing pass over all 4**MAX_KMER entries (65536 at the default) with
// in_ch.ready low. A stalled result holds the block in its update cycle.
`default_nettype none

module kmer_counter #(
  parameter int MAX_KMER   = 8,
  parameter int COUNT_BITS = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  kc_in_if.sink      in_ch,
  kc_out_if.source   out_ch,
  kc_cfg_if.sink     cfg_ch
);

  kc_pkg::ctrl_cmd_t  cmd;
  kc_pkg::dp_status_t status;

  // The length register takes a write in any cycle.
  assign cfg_ch.ready = 1'b1;

  kc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  kc_datapath #(
    .MAX_KMER   (MAX_KMER),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_ch.valid),
    .cfg_kmer_length (cfg_ch.kmer_length),
    .in_command      (in_ch.command),
    .in_base         (in_ch.base),
    .out_ready       (out_ch.ready),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_ch.valid),
    .out_kmer_code   (out_ch.kmer_code),
    .out_occurrences (out_ch.occurrences),
    .out_saturated   (out_ch.saturated)
  );

endmodule

`default_nettype wire

// File: rtl/kc_ctrl.sv
`default_nettype none

module kc_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  kc_pkg::dp_status_t  status,
  output logic                in_ready,
  output kc_pkg::ctrl_cmd_t   cmd
);

  kc_pkg::state_t state_r;
  kc_pkg::state_t state_nxt;

  // State register; reset starts with a pass that zeroes the table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kc_pkg::ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      kc_pkg::ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_nxt = kc_pkg::ST_IDLE;
        end
      end
      kc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (status.is_clear) begin
            state_nxt = kc_pkg::ST_SWEEP;
          end else if (status.emit) begin
            state_nxt = kc_pkg::ST_UPDATE;
          end
        end
      end
      kc_pkg::ST_UPDATE: begin
        // Wait here until the result register can take the new count.
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_nxt  = kc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kc_pkg::ST_SWEEP;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/kc_datapath.sv
`default_nettype none

module kc_datapath #(
  parameter int MAX_KMER   = 8,
  parameter int COUNT_BITS = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_valid,
  input  wire [kc_pkg::LEN_W-1:0]    cfg_kmer_length,
  input  wire                        in_command,
  input  wire [1:0]                  in_base,
  input  wire                        out_ready,
  input  kc_pkg::ctrl_cmd_t          cmd,
  output kc_pkg::dp_status_t         status,
  output logic                       out_valid,
  output logic [kc_pkg::CODE_W-1:0]  out_kmer_code,
  output logic [kc_pkg::OCC_W-1:0]   out_occurrences,
  output logic                       out_saturated
);

  localparam int ADDR_W = 2 * MAX_KMER;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int HELD_W = $clog2(MAX_KMER + 1);

  localparam logic [kc_pkg::LEN_W-1:0] MAX_LEN  = kc_pkg::LEN_W'(MAX_KMER);
  localparam logic [HELD_W-1:0]        MAX_HELD = HELD_W'(MAX_KMER);

  // Configuration register.
  logic [kc_pkg::LEN_W-1:0] kmer_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_length_r <= kc_pkg::KMER_LEN_RESET;
    end else if (cfg_valid) begin
      kmer_length_r <= cfg_kmer_length;
    end
  end

  // Effective length, clamped to 1..MAX_KMER.
  logic [kc_pkg::LEN_W-1:0] k_eff;

  always_comb begin
    if (kmer_length_r == '0) begin
      k_eff = kc_pkg::LEN_W'(1);
    end else if (kmer_length_r > MAX_LEN) begin
      k_eff = MAX_LEN;
    end else begin
      k_eff = kmer_length_r;
    end
  end

  // Window and fill count after the incoming base.
  logic [ADDR_W-1:0] window_r, window_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [ADDR_W-1:0] code_mask;
  logic [ADDR_W-1:0] code_nxt;

  assign window_nxt = (window_r << 2) | ADDR_W'(in_base);
  assign held_nxt   = (held_r == MAX_HELD) ? held_r : held_r + HELD_W'(1);
  assign code_mask  = ~({ADDR_W{1'b1}} << {k_eff, 1'b0});
  assign code_nxt   = window_nxt & code_mask;

  assign status.is_clear = (in_command == kc_pkg::CMD_CLEAR);
  assign status.emit     = (kc_pkg::LEN_W'(held_nxt) >= k_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      held_r   <= '0;
    end else if (cmd.take) begin
      if (status.is_clear) begin
        window_r <= '0;
        held_r   <= '0;
      end else begin
        window_r <= window_nxt;
        held_r   <= held_nxt;
      end
    end
  end

  // Sweep address for zeroing the table.
  logic [ADDR_W-1:0] sweep_cnt_r;

  assign status.sweep_last = &sweep_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_cnt_r <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt_r <= sweep_cnt_r + ADDR_W'(1);
    end
  end

  // Counter table: one write port, one registered read port.
  logic [COUNT_BITS-1:0] count_mem [DEPTH];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic [ADDR_W-1:0]     code_r;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                  sat;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  assign sat       = &rd_data_r;
  assign cnt_new   = sat ? rd_data_r : rd_data_r + COUNT_BITS'(1);
  assign mem_we    = cmd.sweep | cmd.update;
  assign mem_waddr = cmd.sweep ? sweep_cnt_r : code_r;
  assign mem_wdata = cmd.sweep ? '0 : cnt_new;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.take) begin
      rd_data_r <= count_mem[code_nxt];
      code_r    <= code_nxt;
    end
  end

  // Field formatting for the result.
  logic [kc_pkg::CODE_W-1:0]         code_field;
  logic [kc_pkg::OCC_W-1:0]          occ_field;
  logic [ADDR_W+kc_pkg::CODE_W-1:0]  code_ext;

  assign code_ext   = {{kc_pkg::CODE_W{1'b0}}, code_r};
  assign code_field = code_ext[kc_pkg::CODE_W-1:0];

  if (COUNT_BITS > kc_pkg::OCC_W) begin : g_wide_count
    assign occ_field = (|cnt_new[COUNT_BITS-1:kc_pkg::OCC_W]) ? '1
                                                               : cnt_new[kc_pkg::OCC_W-1:0];
  end else begin : g_narrow_count
    logic [COUNT_BITS+kc_pkg::OCC_W-1:0] cnt_ext;
    assign cnt_ext   = {{kc_pkg::OCC_W{1'b0}}, cnt_new};
    assign occ_field = cnt_ext[kc_pkg::OCC_W-1:0];
  end

  // Result register; it frees up in the cycle the sink takes it.
  logic                      out_valid_r;
  logic [kc_pkg::CODE_W-1:0] out_code_r;
  logic [kc_pkg::OCC_W-1:0]  out_occ_r;
  logic                      out_sat_r;

  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_code_r <= code_field;
      out_occ_r  <= occ_field;
      out_sat_r  <= sat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kmer_code   = out_code_r;
  assign out_occurrences = out_occ_r;
  assign out_saturated   = out_sat_r;

endmodule

`default_nettype wire

// File: rtl/kc_checker.sv
`default_nettype none

module kc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        in_command,
  input wire        out_valid,
  input wire        out_ready,
  input wire [15:0] out_kmer_code,
  input wire [15:0] out_occurrences
);

  // A result waiting on the sink stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kmer_code) && $stable(out_occurrences))
    else $error("result payload changed while stalled");

  // An accepted clear starts the zeroing pass, so no input is taken next cycle.
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == kc_pkg::CMD_CLEAR) |=> !in_ready)
    else $error("input accepted right after a clear");

  // A new result comes from the update cycle, in which no input is taken.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an update cycle");

endmodule

bind kmer_counter kc_checker u_kc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_command      (in_ch.command),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kmer_code   (out_ch.kmer_code),
  .out_occurrences (out_ch.occurrences)
);

`default_nettype wire

// File: sim/kmer_counter_test.sv
`default_nettype none

module kmer_counter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_K       = 8;
  localparam int COUNT_MAX   = 65535;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int REPORT_MAX  = 10;

  // Shapes of the random base runs.
  typedef enum int {
    RUN_NOISE,
    RUN_REPEAT,
    RUN_PERIODIC,
    RUN_PAIR
  } run_style_t;

  // One counted k-mer as the result channel carries it.
  typedef struct packed {
    logic [kc_pkg::CODE_W-1:0] code;
    logic [kc_pkg::OCC_W-1:0]  occ;
    logic                      sat;
  } kmer_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  kc_in_if  in_ch();
  kc_out_if out_ch();
  kc_cfg_if cfg_ch();

  kmer_counter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the counter state.
  logic [kc_pkg::CODE_W-1:0] window_q;
  int unsigned               held_q;
  logic [kc_pkg::LEN_W-1:0]  length_q;
  int unsigned               count_tbl [int unsigned];

  kmer_result_t expected_counts [$];

  int unsigned mismatches = 0;
  int unsigned n_pushes = 0;
  int unsigned n_clears = 0;
  int unsigned n_checked = 0;
  int unsigned n_len_writes = 0;
  int unsigned cycle_count = 0;

  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Count a failure and print the first few of them.
  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
  endfunction

  // Update the shadow state for one accepted item and queue its count, if any.
  function automatic void count_item(input kc_pkg::cmd_code_t cmd, input logic [1:0] b);
    int unsigned  k;
    int unsigned  cnt;
    logic [31:0]  mask;
    logic [kc_pkg::CODE_W-1:0] code;
    kmer_result_t r;
    if (cmd == kc_pkg::CMD_CLEAR) begin
      window_q = '0;
      held_q = 0;
      count_tbl.delete();
      return;
    end
    window_q = {window_q[kc_pkg::CODE_W-3:0], b};
    if (held_q < MAX_K) held_q++;
    // Out-of-range lengths fold to the nearest legal one.
    if (length_q == 0) k = 1;
    else if (length_q > MAX_K) k = MAX_K;
    else k = 32'(length_q);
    if (held_q < k) return;
    mask = (32'd1 << (2 * k)) - 32'd1;
    code = window_q & mask[kc_pkg::CODE_W-1:0];
    cnt = count_tbl.exists(code) ? count_tbl[code] : 0;
    r.sat = (cnt >= COUNT_MAX);
    if (!r.sat) cnt++;
    count_tbl[code] = cnt;
    r.code = code;
    r.occ = cnt[kc_pkg::OCC_W-1:0];
    expected_counts = {expected_counts, r};
  endfunction

  // Offer one item and wait for its transaction.
  task automatic send_item(input kc_pkg::cmd_code_t cmd, input logic [1:0] b);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 20) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.base <= b;
    do @(posedge clk); while (!in_ch.ready);
    count_item(cmd, b);
    if (cmd == kc_pkg::CMD_CLEAR) n_clears++;
    else n_pushes++;
  endtask

  // Write the length register once the block has drained.
  task automatic write_length(input logic [kc_pkg::LEN_W-1:0] len);
    in_ch.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.kmer_length <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    length_q = len;
    n_len_writes++;
  endtask

  // Reset length: the first three bases only fill the window.
  task automatic test_fill_window();
    send_item(kc_pkg::CMD_PUSH, 2'd3);
    send_item(kc_pkg::CMD_PUSH, 2'd3);
    send_item(kc_pkg::CMD_PUSH, 2'd3);
    send_item(kc_pkg::CMD_PUSH, 2'd3);
    send_item(kc_pkg::CMD_PUSH, 2'd0);
    send_item(kc_pkg::CMD_PUSH, 2'd1);
  endtask

  // A clear mid-window empties both the window and the table.
  task automatic test_clear();
    send_item(kc_pkg::CMD_PUSH, 2'd0);
    send_item(kc_pkg::CMD_PUSH, 2'd1);
    send_item(kc_pkg::CMD_CLEAR, 2'd3);
    send_item(kc_pkg::CMD_PUSH, 2'd2);
    send_item(kc_pkg::CMD_PUSH, 2'd2);
    send_item(kc_pkg::CMD_PUSH, 2'd2);
    send_item(kc_pkg::CMD_PUSH, 2'd2);
  endtask

  // Longest, shortest and out-of-range lengths, each applied to held bases.
  task automatic test_lengths();
    write_length(4'd8);
    send_item(kc_pkg::CMD_PUSH, 2'd3);
    send_item(kc_pkg::CMD_PUSH, 2'd0);
    send_item(kc_pkg::CMD_PUSH, 2'd3);
    send_item(kc_pkg::CMD_PUSH, 2'd0);
    send_item(kc_pkg::CMD_PUSH, 2'd1);
    send_item(kc_pkg::CMD_PUSH, 2'd2);
    write_length(4'd1);
    send_item(kc_pkg::CMD_PUSH, 2'd2);
    send_item(kc_pkg::CMD_PUSH, 2'd2);
    write_length(4'd0);
    send_item(kc_pkg::CMD_PUSH, 2'd1);
    write_length(4'd15);
    send_item(kc_pkg::CMD_PUSH, 2'd3);
    send_item(kc_pkg::CMD_PUSH, 2'd3);
  endtask

  // The receiver holds off while the sender keeps offering pushes.
  task automatic test_backpressure();
    int i;
    write_length(4'd2);
    hold_off_req = 1'b1;
    for (i = 0; i < 30; i++) begin
      send_item(kc_pkg::CMD_PUSH, 2'($urandom));
    end
  endtask

  // Count one k-mer many times with no idling on either side.
  task automatic test_no_idle();
    int i;
    write_length(4'd1);
    no_idle = 1'b1;
    for (i = 0; i < 80; i++) begin
      send_item(kc_pkg::CMD_PUSH, 2'd0);
    end
    no_idle = 1'b0;
  endtask

  // Random stream made of runs that repeat k-mers, plus noise runs.
  task automatic test_random_stream(input logic [kc_pkg::LEN_W-1:0] len, input int n_items,
                                    input bit start_clear, input int mid_clear_at);
    int          i;
    int          run_left;
    int          period;
    run_style_t  style;
    logic [1:0]  pattern [4];
    logic [1:0]  b;
    write_length(len);
    if (start_clear) send_item(kc_pkg::CMD_CLEAR, 2'($urandom));
    run_left = 0;
    style = RUN_NOISE;
    period = 1;
    for (i = 0; i < n_items; i++) begin
      if (i == mid_clear_at) begin
        send_item(kc_pkg::CMD_CLEAR, 2'($urandom));
        continue;
      end
      if (run_left == 0) begin
        style = run_style_t'($urandom_range(0, 3));
        run_left = $urandom_range(4, 24);
        period = $urandom_range(1, 4);
        foreach (pattern[j]) pattern[j] = 2'($urandom);
      end
      case (style)
        RUN_NOISE: begin
          b = 2'($urandom);
        end
        RUN_REPEAT: begin
          b = pattern[0];
        end
        RUN_PERIODIC: begin
          b = pattern[i % period];
        end
        default: begin
          b = pattern[$urandom_range(0, 1)];
        end
      endcase
      run_left--;
      send_item(kc_pkg::CMD_PUSH, b);
    end
  endtask

  // Result receiver: random idling, plus one long hold-off on request.
  initial begin : drive_result_ready
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  // Compare each result transaction with the oldest expected count.
  always @(posedge clk) begin : check_results
    kmer_result_t want;
    kmer_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.kmer_code, out_ch.occurrences, out_ch.saturated};
      if (expected_counts.size() == 0) begin
        flag_error($sformatf("unexpected result code %h occ %0d sat %0b",
                             got.code, got.occ, got.sat));
      end else begin
        want = expected_counts.pop_front();
        n_checked++;
        if (got.code !== want.code || got.occ !== want.occ || got.sat !== want.sat) begin
          flag_error($sformatf("expected code %h occ %0d sat %0b, got code %h occ %0d sat %0b",
                               want.code, want.occ, want.sat, got.code, got.occ, got.sat));
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, expected_counts.size());
    $display("FAILED: results differ");
    $finish;
  end

  // Test sequence.
  initial begin
    // Known values on every input from time zero.
    in_ch.valid = 1'b0;
    in_ch.command = kc_pkg::CMD_PUSH;
    in_ch.base = 2'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.kmer_length = '0;
    window_q = '0;
    held_q = 0;
    length_q = kc_pkg::KMER_LEN_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_fill_window();
    test_clear();
    test_lengths();
    test_backpressure();
    test_no_idle();
    test_random_stream(4'd1, 70, 1'b0, -1);
    test_random_stream(4'd8, 70, 1'b1, -1);
    test_random_stream(4'($urandom_range(2, 7)), 70, 1'b0, $urandom_range(15, 55));
    test_random_stream(4'($urandom_range(0, 15)), 70, 1'b0, -1);

    in_ch.valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d pushes and %0d clears over %0d length writes (0, 1, 8, 15 included),",
             n_pushes, n_clears, n_len_writes);
    $display("with %0d counts checked, a long stretch without idling and a long result stall.",
             n_checked);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/kc_pkg.sv
rtl/kc_if.sv
rtl/kc_ctrl.sv
rtl/kc_datapath.sv
rtl/kmer_counter.sv
rtl/kc_checker.sv
sim/kmer_counter_test.sv
